### hw/rtl/mhpq_pkg.sv
`default_nettype none

package mhpq_pkg;

  // Heap geometry.
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CHILD_W  = IDX_W + 2;

  // Payload widths.
  localparam int WORD_W   = 32;
  localparam int ENTRY_W  = 2 * WORD_W;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  localparam logic [WORD_W-1:0] INT_MIN   = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic [WORD_W-1:0] SIGN_FLIP = {1'b1, {(WORD_W-1){1'b0}}};

  // Command codes. Any code with bit 1 set behaves as a peek.
  localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EXTRACT = 2'd1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,       // capture the new pair, hole at the first free slot
    OP_ROOT_READ,  // read the root and the last entry
    OP_TAKE_TOP,   // latch the root
    OP_TAKE_LAST,  // latch the root, pull the last entry, shrink the heap
    OP_UP_READ,    // read the parent of the hole
    OP_UP_MOVE,    // move the parent down into the hole
    OP_PUT_INC,    // write the pair into the hole and grow the heap
    OP_DN_READ,    // read both children of the hole
    OP_DN_MOVE,    // move the smaller child up into the hole
    OP_PUT         // write the pair into the hole
  } dp_op_t;

  // Kind of result loaded into the output register.
  typedef enum logic [1:0] {
    RES_INSERT,
    RES_FULL,
    RES_EMPTY,
    RES_TOP
  } res_kind_t;

  typedef struct packed {
    dp_op_t    op;
    logic      res_load;
    res_kind_t res_kind;
  } mhpq_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic pos_zero;
    logic has_left;
    logic up_swap;
    logic dn_move;
  } mhpq_stat_t;

endpackage

`default_nettype wire

### hw/rtl/mhpq_if.sv
`default_nettype none

// Command channel.
interface mhpq_in_if;
  import mhpq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic signed [WORD_W-1:0] key;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, output cmd, output key, output value, input ready);
  modport sink   (input valid, input cmd, input key, input value, output ready);
endinterface

// Result channel.
interface mhpq_out_if;
  import mhpq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] out_key;
  logic signed [WORD_W-1:0] out_value;
  logic [STATUS_W-1:0]      status;
  logic [COUNT_W-1:0]       count;

  modport source (output valid, output out_key, output out_value, output status,
                  output count, input ready);
  modport sink   (input valid, input out_key, input out_value, input status,
                  input count, output ready);
endinterface

`default_nettype wire

### hw/rtl/mhpq_datapath.sv
`default_nettype none

module mhpq_datapath
  import mhpq_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire mhpq_ctrl_t               ctrl,
  input  wire logic [WORD_W-1:0]        in_key,
  input  wire logic [WORD_W-1:0]        in_value,
  output mhpq_stat_t                    stat,
  output logic signed [WORD_W-1:0]      res_key,
  output logic signed [WORD_W-1:0]      res_value,
  output logic [STATUS_W-1:0]           res_status,
  output logic [COUNT_W-1:0]            res_count
);

  // Heap storage; entries hold sign-flipped key and value so that one
  // unsigned compare gives the pair order.
  logic [ENTRY_W-1:0] heap_mem [CAPACITY];

  logic [ENTRY_W-1:0] rd_a_r;
  logic [ENTRY_W-1:0] rd_b_r;
  logic [ENTRY_W-1:0] item_r;
  logic [ENTRY_W-1:0] top_r;
  logic [IDX_W-1:0]   pos_r;
  logic [CNT_W-1:0]   count_r;

  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr_a;
  logic [IDX_W-1:0]   rd_addr_b;
  logic               wr_en;
  logic [ENTRY_W-1:0] wr_data;

  logic [IDX_W-1:0]   parent_idx;
  logic [CHILD_W-1:0] left_idx;
  logic [CHILD_W-1:0] right_idx;
  logic [CHILD_W-1:0] count_ext;
  logic               left_ok;
  logic               right_ok;
  logic               left_lt;
  logic               pick_right;
  logic [IDX_W-1:0]   best_idx;
  logic [ENTRY_W-1:0] best_data;

  // Tree neighbors of the hole.
  always_comb begin
    parent_idx = (pos_r - IDX_W'(1)) >> 1;
    left_idx   = {1'b0, pos_r, 1'b1};
    right_idx  = left_idx + CHILD_W'(1);
    count_ext  = CHILD_W'(count_r);
    left_ok    = left_idx < count_ext;
    right_ok   = right_idx < count_ext;
  end

  // Child selection; ties keep the pair in place and prefer the left child.
  always_comb begin
    left_lt    = left_ok && (rd_a_r < item_r);
    pick_right = right_ok && (left_lt ? (rd_b_r < rd_a_r) : (rd_b_r < item_r));
    best_idx   = pick_right ? right_idx[IDX_W-1:0] : left_idx[IDX_W-1:0];
    best_data  = pick_right ? rd_b_r : rd_a_r;
  end

  // Status back to the controller.
  always_comb begin
    stat.empty    = (count_r == '0);
    stat.full     = (count_r == CNT_W'(CAPACITY));
    stat.pos_zero = (pos_r == '0);
    stat.has_left = left_ok;
    stat.up_swap  = (rd_a_r > item_r);
    stat.dn_move  = left_lt || pick_right;
  end

  // Memory port control.
  always_comb begin
    rd_en     = 1'b0;
    rd_addr_a = '0;
    rd_addr_b = '0;
    wr_en     = 1'b0;
    wr_data   = item_r;
    case (ctrl.op)
      OP_ROOT_READ: begin
        rd_en     = 1'b1;
        rd_addr_b = IDX_W'(count_r - CNT_W'(1));
      end
      OP_UP_READ: begin
        rd_en     = 1'b1;
        rd_addr_a = parent_idx;
      end
      OP_DN_READ: begin
        rd_en     = 1'b1;
        rd_addr_a = left_idx[IDX_W-1:0];
        rd_addr_b = right_idx[IDX_W-1:0];
      end
      OP_UP_MOVE: begin
        wr_en   = 1'b1;
        wr_data = rd_a_r;
      end
      OP_DN_MOVE: begin
        wr_en   = 1'b1;
        wr_data = best_data;
      end
      OP_PUT, OP_PUT_INC: begin
        wr_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Memory with registered reads.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      heap_mem[pos_r] <= wr_data;
    end
    if (rd_en) begin
      rd_a_r <= heap_mem[rd_addr_a];
      rd_b_r <= heap_mem[rd_addr_b];
    end
  end

  // Working registers for the moving pair, the hole and the root.
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: begin
        item_r <= {in_key ^ SIGN_FLIP, in_value ^ SIGN_FLIP};
        pos_r  <= count_r[IDX_W-1:0];
      end
      OP_TAKE_TOP: begin
        top_r <= rd_a_r;
      end
      OP_TAKE_LAST: begin
        top_r  <= rd_a_r;
        item_r <= rd_b_r;
        pos_r  <= '0;
      end
      OP_UP_MOVE: begin
        pos_r <= parent_idx;
      end
      OP_DN_MOVE: begin
        pos_r <= best_idx;
      end
      default: begin
      end
    endcase
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctrl.op == OP_PUT_INC) begin
      count_r <= count_r + CNT_W'(1);
    end else if (ctrl.op == OP_TAKE_LAST) begin
      count_r <= count_r - CNT_W'(1);
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (ctrl.res_load) begin
      res_count <= COUNT_W'(count_r);
      case (ctrl.res_kind)
        RES_INSERT: begin
          res_key    <= '0;
          res_value  <= '0;
          res_status <= ST_OK;
        end
        RES_FULL: begin
          res_key    <= '0;
          res_value  <= '0;
          res_status <= ST_FULL;
        end
        RES_EMPTY: begin
          res_key    <= INT_MIN;
          res_value  <= INT_MIN;
          res_status <= ST_EMPTY;
        end
        default: begin
          res_key    <= top_r[ENTRY_W-1:WORD_W] ^ SIGN_FLIP;
          res_value  <= top_r[WORD_W-1:0] ^ SIGN_FLIP;
          res_status <= ST_OK;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/mhpq_controller.sv
`default_nettype none

module mhpq_controller
  import mhpq_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [CMD_W-1:0] in_cmd,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire mhpq_stat_t       stat,
  output mhpq_ctrl_t            ctrl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAKE,
    S_UP_CHECK,
    S_UP_CMP,
    S_DN_CHECK,
    S_DN_CMP,
    S_FIN
  } state_t;

  state_t    state_r, state_nxt;
  logic      out_valid_r, out_valid_nxt;
  res_kind_t res_kind_r, res_kind_nxt;
  logic      is_peek_r, is_peek_nxt;
  logic      accept;
  logic      res_load;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;
  assign res_load  = (state_r == S_FIN) && (!out_valid_r || out_ready);

  // Next state and datapath command.
  always_comb begin
    state_nxt    = state_r;
    res_kind_nxt = res_kind_r;
    is_peek_nxt  = is_peek_r;
    ctrl.op      = OP_NONE;
    ctrl.res_load = res_load;
    ctrl.res_kind = res_kind_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          is_peek_nxt = (in_cmd != CMD_INSERT) && (in_cmd != CMD_EXTRACT);
          if (in_cmd == CMD_INSERT) begin
            if (stat.full) begin
              res_kind_nxt = RES_FULL;
              state_nxt    = S_FIN;
            end else begin
              res_kind_nxt = RES_INSERT;
              ctrl.op      = OP_LOAD;
              state_nxt    = S_UP_CHECK;
            end
          end else if (stat.empty) begin
            res_kind_nxt = RES_EMPTY;
            state_nxt    = S_FIN;
          end else begin
            res_kind_nxt = RES_TOP;
            ctrl.op      = OP_ROOT_READ;
            state_nxt    = S_TAKE;
          end
        end
      end
      S_TAKE: begin
        if (is_peek_r) begin
          ctrl.op   = OP_TAKE_TOP;
          state_nxt = S_FIN;
        end else begin
          ctrl.op   = OP_TAKE_LAST;
          state_nxt = S_DN_CHECK;
        end
      end
      S_UP_CHECK: begin
        if (stat.pos_zero) begin
          ctrl.op   = OP_PUT_INC;
          state_nxt = S_FIN;
        end else begin
          ctrl.op   = OP_UP_READ;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (stat.up_swap) begin
          ctrl.op   = OP_UP_MOVE;
          state_nxt = S_UP_CHECK;
        end else begin
          ctrl.op   = OP_PUT_INC;
          state_nxt = S_FIN;
        end
      end
      S_DN_CHECK: begin
        if (stat.has_left) begin
          ctrl.op   = OP_DN_READ;
          state_nxt = S_DN_CMP;
        end else begin
          ctrl.op   = OP_PUT;
          state_nxt = S_FIN;
        end
      end
      S_DN_CMP: begin
        if (stat.dn_move) begin
          ctrl.op   = OP_DN_MOVE;
          state_nxt = S_DN_CHECK;
        end else begin
          ctrl.op   = OP_PUT;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (res_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result beat held until the sink takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      res_kind_r  <= RES_INSERT;
      is_peek_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      res_kind_r  <= res_kind_nxt;
      is_peek_r   <= is_peek_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/min_heap_priority_queue_core.sv
`default_nettype none

// Binary min-heap priority queue of signed 32-bit (key, value) pairs, ordered
// by key and then by value, holding up to CAPACITY pairs in a single-write,
// dual-read memory. Each command beat yields exactly one result beat: insert
// sifts the pair up, extract returns the root and sifts the last entry down
// from the root, peek returns the root. The block works on one command at a
// time. An insert into a full heap, or an extract or peek on an empty heap,
// goes straight to its result. Each tree level the pair moves costs one memory
// read of the parent or both children, then one compare and move; a walk that
// stops short of the root or a leaf ends with a read and compare that find no
// move. At 64 entries the worst case is an insert that climbs all six levels
// to the root, and the next command can be taken in the cycle after the
// result is loaded. A result that waits for the sink holds the block in its
// final step, but a new command is accepted while the previous result still
// waits in the output register.
module min_heap_priority_queue_core
  import mhpq_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  mhpq_in_if.sink     in_ch,
  mhpq_out_if.source  out_ch
);

  mhpq_ctrl_t ctrl;
  mhpq_stat_t stat;
  logic       in_ready;
  logic       out_valid;

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  // Sequencer for sift-up and sift-down walks.
  mhpq_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .in_cmd    (in_ch.cmd),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  // Heap memory, compare logic and result register.
  mhpq_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .in_key     (in_ch.key),
    .in_value   (in_ch.value),
    .stat       (stat),
    .res_key    (out_ch.out_key),
    .res_value  (out_ch.out_value),
    .res_status (out_ch.status),
    .res_count  (out_ch.count)
  );

endmodule

`default_nettype wire
